// ===== design/mgc_pkg.sv =====
`timescale 1ns / 1ps
package mgc_pkg;

    localparam int VOLT_W         = 24;
    localparam int CAP_W          = 32;
    localparam int CHG_W          = 48;
    localparam int PHI_W          = 23;
    localparam int VOLT_FRAC_BITS = 16;

    localparam logic [PHI_W-1:0] PHI_RESET = 23'd39322;

    // shared long-division lanes
    localparam int NUM_W   = 83;
    localparam int DEN_W   = 52;
    localparam int QUO_W   = 33;
    localparam int DIV_LAT = QUO_W + 1;

    // split point of the 50-bit square difference for the partial products
    localparam int HALF_W = 25;

    typedef struct packed {
        logic [CAP_W-1:0]  ov_gb;
        logic [CAP_W-1:0]  ov_gd;
        logic [CAP_W-1:0]  ov_gs;
        logic [VOLT_W-1:0] volt_gb;
        logic [VOLT_W-1:0] volt_gd;
        logic [VOLT_W-1:0] volt_gs;
        logic              x_gd;
        logic              neg_gd;
        logic              neg_gs;
        logic              fault;
    } t_side;

endpackage

// ===== design/mgc_if.sv =====
`timescale 1ns / 1ps
interface mgc_in_if;
    logic                          valid;
    logic                          ready;
    logic [mgc_pkg::VOLT_W-1:0]    gate_overdrive;
    logic [mgc_pkg::VOLT_W-1:0]    drain_source_volt;
    logic [mgc_pkg::VOLT_W-1:0]    saturation_volt;
    logic [mgc_pkg::VOLT_W-1:0]    bulk_source_volt;
    logic [mgc_pkg::CAP_W-1:0]     oxide_cap;
    logic [mgc_pkg::CAP_W-1:0]     overlap_gb;
    logic [mgc_pkg::CAP_W-1:0]     overlap_gd;
    logic [mgc_pkg::CAP_W-1:0]     overlap_gs;
    logic [mgc_pkg::VOLT_W-1:0]    volt_gb;
    logic [mgc_pkg::VOLT_W-1:0]    volt_gd;
    logic [mgc_pkg::VOLT_W-1:0]    volt_gs;

    modport source (
        output valid, gate_overdrive, drain_source_volt, saturation_volt,
               bulk_source_volt, oxide_cap, overlap_gb, overlap_gd, overlap_gs,
               volt_gb, volt_gd, volt_gs,
        input  ready
    );
    modport sink (
        input  valid, gate_overdrive, drain_source_volt, saturation_volt,
               bulk_source_volt, oxide_cap, overlap_gb, overlap_gd, overlap_gs,
               volt_gb, volt_gd, volt_gs,
        output ready
    );
endinterface

interface mgc_out_if;
    logic                          valid;
    logic                          ready;
    logic [mgc_pkg::CAP_W-1:0]     cap_gb;
    logic [mgc_pkg::CAP_W-1:0]     cap_gd;
    logic [mgc_pkg::CAP_W-1:0]     cap_gs;
    logic [mgc_pkg::CHG_W-1:0]     charge_gb;
    logic [mgc_pkg::CHG_W-1:0]     charge_gd;
    logic [mgc_pkg::CHG_W-1:0]     charge_gs;
    logic                          divide_fault;

    modport source (
        output valid, cap_gb, cap_gd, cap_gs, charge_gb, charge_gd, charge_gs,
               divide_fault,
        input  ready
    );
    modport sink (
        input  valid, cap_gb, cap_gd, cap_gs, charge_gb, charge_gd, charge_gs,
               divide_fault,
        output ready
    );
endinterface

// ===== design/mgc_div.sv =====
`timescale 1ns / 1ps
module mgc_div (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [mgc_pkg::NUM_W-1:0]   i_num,
    input  logic [mgc_pkg::DEN_W-1:0]   i_den,
    output logic [mgc_pkg::QUO_W-1:0]   o_quo,
    output logic                        o_ovf
);

    logic [mgc_pkg::DEN_W-1:0] r_rem [0:mgc_pkg::QUO_W];
    logic [mgc_pkg::DEN_W-1:0] r_den [0:mgc_pkg::QUO_W];
    logic [mgc_pkg::QUO_W-1:0] r_low [0:mgc_pkg::QUO_W];
    logic [mgc_pkg::QUO_W-1:0] r_quo [0:mgc_pkg::QUO_W];
    logic                      r_ovf [0:mgc_pkg::QUO_W];

    // quotient needs more than QUO_W bits when the top part already reaches the divisor
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= mgc_pkg::DEN_W'(i_num[mgc_pkg::NUM_W-1:mgc_pkg::QUO_W]);
            r_ovf[0] <= (mgc_pkg::DEN_W'(i_num[mgc_pkg::NUM_W-1:mgc_pkg::QUO_W]) >= i_den);
            r_low[0] <= i_num[mgc_pkg::QUO_W-1:0];
            r_den[0] <= i_den;
            r_quo[0] <= '0;
        end
    end

    // one restoring step per stage, msb first
    for (genvar k = 1; k <= mgc_pkg::QUO_W; k++) begin : g_step
        logic [mgc_pkg::DEN_W:0] w_try;
        logic [mgc_pkg::DEN_W:0] w_sub;
        logic                    w_ge;

        always_comb begin
            w_try = {r_rem[k-1], r_low[k-1][mgc_pkg::QUO_W-k]};
            w_sub = w_try - {1'b0, r_den[k-1]};
            w_ge  = (w_try >= {1'b0, r_den[k-1]});
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= w_ge ? w_sub[mgc_pkg::DEN_W-1:0] : w_try[mgc_pkg::DEN_W-1:0];
                r_quo[k] <= {r_quo[k-1][mgc_pkg::QUO_W-2:0], w_ge};
                r_low[k] <= r_low[k-1];
                r_den[k] <= r_den[k-1];
                r_ovf[k] <= r_ovf[k-1];
            end
        end
    end

    assign o_quo = r_quo[mgc_pkg::QUO_W];
    assign o_ovf = r_ovf[mgc_pkg::QUO_W];

endmodule

// ===== design/meyer_gate_capacitance_top.sv =====
`timescale 1ns / 1ps
// Meyer gate capacitance evaluator. Each input transaction carries one MOS
// operating point; one result transaction comes back with the gate-bulk,
// gate-drain and gate-source capacitances (overlap plus Meyer region term,
// saturated to 32 bits), the three branch charges (volt times cap, floored)
// and a flag for a zero linear-region denominator. The surface potential phi
// is written through i_cfg_wr_en / i_cfg_wr_data, by the user only while the
// block is idle (the block itself does not enforce this), and resets to about
// 0.6 V. The block is a flat pipeline of 42 register stages: one transaction
// per clock in and out while the output is not stalled. Most of those stages
// are the two 34-stage restoring dividers (operand capture plus one quotient
// bit per stage) that form the region quotients; the rest are operand setup,
// squares, partial products, the capacitance clamp and the charge multiply.
// The pipeline moves as a whole whenever the output register is empty or
// being taken, so a stall at the output holds every stage and nothing is lost
// or repeated.
module meyer_gate_capacitance_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_wr_en,
    input  logic [mgc_pkg::PHI_W-1:0]   i_cfg_wr_data,
    mgc_in_if.sink                      i_in,
    mgc_out_if.source                   o_out
);

    localparam int VLD_N = 7 + mgc_pkg::DIV_LAT;

    // capacitance sum: overlap plus a signed term, clamped to the 32-bit range
    // a quotient overflow means the term alone is past the 32-bit range
    function automatic logic [mgc_pkg::CAP_W-1:0] cap_sum(
        input logic [mgc_pkg::CAP_W-1:0] ov,
        input logic [mgc_pkg::QUO_W-1:0] mag,
        input logic                      ovf,
        input logic                      neg
    );
        logic [mgc_pkg::CAP_W:0]   ov33;
        logic [mgc_pkg::CAP_W+1:0] sum;
        logic [mgc_pkg::CAP_W:0]   dif;
        logic [mgc_pkg::CAP_W-1:0] res;
        ov33 = {1'b0, ov};
        sum  = {1'b0, ov33} + {1'b0, mag};
        dif  = ov33 - mag;
        if (neg) begin
            res = (ovf || (mag >= ov33)) ? '0 : dif[mgc_pkg::CAP_W-1:0];
        end else begin
            res = (ovf || (sum[mgc_pkg::CAP_W+1:mgc_pkg::CAP_W] != 2'b00)) ? '1
                                                            : sum[mgc_pkg::CAP_W-1:0];
        end
        return res;
    endfunction

    logic w_adv;
    logic [VLD_N-1:0] r_vld;
    logic r_out_valid;
    logic [mgc_pkg::PHI_W-1:0] r_phi;

    assign w_adv      = !r_out_valid || o_out.ready;
    assign i_in.ready = w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phi <= mgc_pkg::PHI_RESET;
        end else if (i_cfg_wr_en) begin
            r_phi <= i_cfg_wr_data;
        end
    end

    // valid bits travel alongside the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_vld       <= {r_vld[VLD_N-2:0], i_in.valid};
            r_out_valid <= r_vld[VLD_N-1];
        end
    end

    // ---------------- stage 1: region decode and differences ----------------
    logic [24:0] w_vgst25;
    logic [24:0] w_nphi25;
    logic        w_neg;
    logic        w_pos;
    logic        w_gb_full;
    logic        w_lin;
    logic [25:0] w_dep26;
    logic        w_dep;
    logic [25:0] w_d;
    logic [24:0] w_ngd;
    logic [24:0] w_ngs;
    logic        w_fault;
    mgc_pkg::t_side w_side;

    always_comb begin
        w_vgst25  = {i_in.gate_overdrive[23], i_in.gate_overdrive};
        w_nphi25  = 25'd0 - {2'b00, r_phi};
        w_neg     = i_in.gate_overdrive[23];
        w_pos     = !w_neg && (i_in.gate_overdrive != '0);
        w_gb_full = ($signed(w_vgst25) < $signed(w_nphi25));
        w_lin     = w_pos && ($signed(i_in.saturation_volt) > $signed(i_in.drain_source_volt));
        // depletion edge: 2*vgst + phi > 0
        w_dep26   = {i_in.gate_overdrive[23], i_in.gate_overdrive, 1'b0} + {3'b000, r_phi};
        w_dep     = !w_pos && !w_dep26[25] && (w_dep26 != '0);
        w_d       = {i_in.saturation_volt[23], i_in.saturation_volt, 1'b0}
                  - {{2{i_in.drain_source_volt[23]}}, i_in.drain_source_volt}
                  - {{2{i_in.bulk_source_volt[23]}}, i_in.bulk_source_volt};
        w_ngd     = {i_in.saturation_volt[23], i_in.saturation_volt}
                  - {i_in.bulk_source_volt[23], i_in.bulk_source_volt};
        w_ngs     = {i_in.saturation_volt[23], i_in.saturation_volt}
                  - {i_in.drain_source_volt[23], i_in.drain_source_volt};
        w_fault   = w_lin && (w_d == '0);

        w_side.ov_gb   = i_in.overlap_gb;
        w_side.ov_gd   = i_in.overlap_gd;
        w_side.ov_gs   = i_in.overlap_gs;
        w_side.volt_gb = i_in.volt_gb;
        w_side.volt_gd = i_in.volt_gd;
        w_side.volt_gs = i_in.volt_gs;
        w_side.x_gd    = w_lin && !w_fault;
        w_side.neg_gd  = 1'b0;
        w_side.neg_gs  = 1'b0;
        w_side.fault   = w_fault;
    end

    logic [25:0]                 r_s1_d;
    logic [24:0]                 r_s1_ngd;
    logic [24:0]                 r_s1_ngs;
    logic [mgc_pkg::CAP_W-1:0]   r_s1_cg;
    logic [23:0]                 r_s1_negv;
    logic [mgc_pkg::PHI_W-1:0]   r_s1_deparg;
    logic [mgc_pkg::PHI_W-1:0]   r_s1_phi;
    logic                        r_s1_gb_full;
    logic                        r_s1_gb_div;
    logic                        r_s1_lin;
    logic                        r_s1_sat;
    logic                        r_s1_dep;
    mgc_pkg::t_side              r_s1_side;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_d       <= w_d;
            r_s1_ngd     <= w_ngd;
            r_s1_ngs     <= w_ngs;
            r_s1_cg      <= i_in.oxide_cap;
            r_s1_negv    <= 24'd0 - i_in.gate_overdrive;
            r_s1_deparg  <= w_dep26[mgc_pkg::PHI_W-1:0];
            r_s1_phi     <= r_phi;
            r_s1_gb_full <= w_gb_full;
            r_s1_gb_div  <= w_neg && !w_gb_full;
            r_s1_lin     <= w_lin && !w_fault;
            r_s1_sat     <= w_pos && !w_lin;
            r_s1_dep     <= w_dep;
            r_s1_side    <= w_side;
        end
    end

    // ---------------- stage 2: squares and depletion / bulk numerators -------
    logic [24:0] w_abs_d;
    logic [24:0] w_abs_ngd;
    logic [24:0] w_abs_ngs;

    always_comb begin
        w_abs_d   = r_s1_d[25] ? 25'(26'd0 - r_s1_d) : r_s1_d[24:0];
        w_abs_ngd = r_s1_ngd[24] ? (25'd0 - r_s1_ngd) : r_s1_ngd;
        w_abs_ngs = r_s1_ngs[24] ? (25'd0 - r_s1_ngs) : r_s1_ngs;
    end

    logic [49:0]                 r_s2_d2;
    logic [49:0]                 r_s2_ngd2;
    logic [49:0]                 r_s2_ngs2;
    logic [55:0]                 r_s2_gbnum;
    logic [55:0]                 r_s2_depnum;
    logic [mgc_pkg::CAP_W-1:0]   r_s2_cg;
    logic [mgc_pkg::PHI_W-1:0]   r_s2_phi;
    logic [24:0]                 r_s2_phi3;
    logic                        r_s2_gb_full;
    logic                        r_s2_gb_div;
    logic                        r_s2_lin;
    logic                        r_s2_sat;
    logic                        r_s2_dep;
    mgc_pkg::t_side              r_s2_side;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s2_d2      <= 50'(w_abs_d) * 50'(w_abs_d);
            r_s2_ngd2    <= 50'(w_abs_ngd) * 50'(w_abs_ngd);
            r_s2_ngs2    <= 50'(w_abs_ngs) * 50'(w_abs_ngs);
            r_s2_gbnum   <= 56'(r_s1_cg) * 56'(r_s1_negv);
            r_s2_depnum  <= 56'({r_s1_cg, 1'b0}) * 56'(r_s1_deparg);
            r_s2_cg      <= r_s1_cg;
            r_s2_phi     <= r_s1_phi;
            r_s2_phi3    <= {1'b0, r_s1_phi, 1'b0} + {2'b00, r_s1_phi};
            r_s2_gb_full <= r_s1_gb_full;
            r_s2_gb_div  <= r_s1_gb_div;
            r_s2_lin     <= r_s1_lin;
            r_s2_sat     <= r_s1_sat;
            r_s2_dep     <= r_s1_dep;
            r_s2_side    <= r_s1_side;
        end
    end

    // ---------------- stage 3: d^2 - n^2 and 3*d^2 ---------------------------
    logic [50:0] w_qgd;
    logic [50:0] w_qgs;

    always_comb begin
        w_qgd = {1'b0, r_s2_d2} - {1'b0, r_s2_ngd2};
        w_qgs = {1'b0, r_s2_d2} - {1'b0, r_s2_ngs2};
    end

    logic [49:0]                 r_s3_mgd;
    logic [49:0]                 r_s3_mgs;
    logic                        r_s3_sgd;
    logic                        r_s3_sgs;
    logic [mgc_pkg::DEN_W-1:0]   r_s3_den3;
    logic [55:0]                 r_s3_gbnum;
    logic [55:0]                 r_s3_depnum;
    logic [mgc_pkg::CAP_W-1:0]   r_s3_cg;
    logic [mgc_pkg::PHI_W-1:0]   r_s3_phi;
    logic [24:0]                 r_s3_phi3;
    logic                        r_s3_gb_full;
    logic                        r_s3_gb_div;
    logic                        r_s3_lin;
    logic                        r_s3_sat;
    logic                        r_s3_dep;
    mgc_pkg::t_side              r_s3_side;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s3_mgd     <= w_qgd[50] ? 50'(51'd0 - w_qgd) : w_qgd[49:0];
            r_s3_mgs     <= w_qgs[50] ? 50'(51'd0 - w_qgs) : w_qgs[49:0];
            r_s3_sgd     <= w_qgd[50];
            r_s3_sgs     <= w_qgs[50];
            r_s3_den3    <= {1'b0, r_s2_d2, 1'b0} + {2'b00, r_s2_d2};
            r_s3_gbnum   <= r_s2_gbnum;
            r_s3_depnum  <= r_s2_depnum;
            r_s3_cg      <= r_s2_cg;
            r_s3_phi     <= r_s2_phi;
            r_s3_phi3    <= r_s2_phi3;
            r_s3_gb_full <= r_s2_gb_full;
            r_s3_gb_div  <= r_s2_gb_div;
            r_s3_lin     <= r_s2_lin;
            r_s3_sat     <= r_s2_sat;
            r_s3_dep     <= r_s2_dep;
            r_s3_side    <= r_s2_side;
        end
    end

    // ---------------- stage 4: 2*C times |d^2 - n^2|, two halves each -------
    logic [mgc_pkg::CAP_W:0] w_cg2;
    mgc_pkg::t_side          w_s4_side;

    always_comb begin
        w_cg2            = {r_s3_cg, 1'b0};
        w_s4_side        = r_s3_side;
        w_s4_side.neg_gd = r_s3_lin && r_s3_sgd;
        w_s4_side.neg_gs = r_s3_lin && r_s3_sgs;
    end

    logic [57:0]                 r_s4_plgd;
    logic [57:0]                 r_s4_phgd;
    logic [57:0]                 r_s4_plgs;
    logic [57:0]                 r_s4_phgs;
    logic [mgc_pkg::DEN_W-1:0]   r_s4_den3;
    logic [55:0]                 r_s4_gbnum;
    logic [55:0]                 r_s4_depnum;
    logic [mgc_pkg::CAP_W-1:0]   r_s4_cg;
    logic [mgc_pkg::PHI_W-1:0]   r_s4_phi;
    logic [24:0]                 r_s4_phi3;
    logic                        r_s4_gb_full;
    logic                        r_s4_gb_div;
    logic                        r_s4_lin;
    logic                        r_s4_sat;
    logic                        r_s4_dep;
    mgc_pkg::t_side              r_s4_side;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s4_plgd    <= 58'(w_cg2) * 58'(r_s3_mgd[mgc_pkg::HALF_W-1:0]);
            r_s4_phgd    <= 58'(w_cg2) * 58'(r_s3_mgd[49:mgc_pkg::HALF_W]);
            r_s4_plgs    <= 58'(w_cg2) * 58'(r_s3_mgs[mgc_pkg::HALF_W-1:0]);
            r_s4_phgs    <= 58'(w_cg2) * 58'(r_s3_mgs[49:mgc_pkg::HALF_W]);
            r_s4_den3    <= r_s3_den3;
            r_s4_gbnum   <= r_s3_gbnum;
            r_s4_depnum  <= r_s3_depnum;
            r_s4_cg      <= r_s3_cg;
            r_s4_phi     <= r_s3_phi;
            r_s4_phi3    <= r_s3_phi3;
            r_s4_gb_full <= r_s3_gb_full;
            r_s4_gb_div  <= r_s3_gb_div;
            r_s4_lin     <= r_s3_lin;
            r_s4_sat     <= r_s3_sat;
            r_s4_dep     <= r_s3_dep;
            r_s4_side    <= w_s4_side;
        end
    end

    // ---------------- stage 5: pick dividend / divisor for each lane ---------
    // lane x serves gate-bulk (negative overdrive) or gate-drain (linear)
    // lane y serves gate-source (linear, saturation or depletion)
    // an unused lane divides zero by one
    logic [mgc_pkg::NUM_W-1:0] w_ngd_num;
    logic [mgc_pkg::NUM_W-1:0] w_ngs_num;
    logic [mgc_pkg::NUM_W-1:0] n_nx;
    logic [mgc_pkg::DEN_W-1:0] n_dx;
    logic [mgc_pkg::NUM_W-1:0] n_ny;
    logic [mgc_pkg::DEN_W-1:0] n_dy;

    always_comb begin
        w_ngd_num = mgc_pkg::NUM_W'(r_s4_plgd)
                  + {r_s4_phgd, {mgc_pkg::HALF_W{1'b0}}};
        w_ngs_num = mgc_pkg::NUM_W'(r_s4_plgs)
                  + {r_s4_phgs, {mgc_pkg::HALF_W{1'b0}}};

        n_nx = '0;
        n_dx = mgc_pkg::DEN_W'(1);
        if (r_s4_lin) begin
            n_nx = w_ngd_num;
            n_dx = r_s4_den3;
        end else if (r_s4_gb_full) begin
            n_nx = mgc_pkg::NUM_W'(r_s4_cg);
        end else if (r_s4_gb_div) begin
            n_nx = mgc_pkg::NUM_W'(r_s4_gbnum);
            n_dx = mgc_pkg::DEN_W'(r_s4_phi);
        end

        n_ny = '0;
        n_dy = mgc_pkg::DEN_W'(1);
        if (r_s4_lin) begin
            n_ny = w_ngs_num;
            n_dy = r_s4_den3;
        end else if (r_s4_sat) begin
            n_ny = mgc_pkg::NUM_W'({r_s4_cg, 1'b0});
            n_dy = mgc_pkg::DEN_W'(3);
        end else if (r_s4_dep) begin
            n_ny = mgc_pkg::NUM_W'(r_s4_depnum);
            n_dy = mgc_pkg::DEN_W'(r_s4_phi3);
        end
    end

    logic [mgc_pkg::NUM_W-1:0] r_s5_nx;
    logic [mgc_pkg::DEN_W-1:0] r_s5_dx;
    logic [mgc_pkg::NUM_W-1:0] r_s5_ny;
    logic [mgc_pkg::DEN_W-1:0] r_s5_dy;
    mgc_pkg::t_side            r_s5_side;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s5_nx   <= n_nx;
            r_s5_dx   <= n_dx;
            r_s5_ny   <= n_ny;
            r_s5_dy   <= n_dy;
            r_s5_side <= r_s4_side;
        end
    end

    // ---------------- dividers, with the sideband delayed to match ----------
    logic [mgc_pkg::QUO_W-1:0] w_qx;
    logic [mgc_pkg::QUO_W-1:0] w_qy;
    logic                      w_ovfx;
    logic                      w_ovfy;

    mgc_div u_div_x (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_num (r_s5_nx),
        .i_den (r_s5_dx),
        .o_quo (w_qx),
        .o_ovf (w_ovfx)
    );

    mgc_div u_div_y (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_num (r_s5_ny),
        .i_den (r_s5_dy),
        .o_quo (w_qy),
        .o_ovf (w_ovfy)
    );

    mgc_pkg::t_side r_dly [0:mgc_pkg::DIV_LAT-1];

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_dly[0] <= r_s5_side;
            for (int i = 1; i < mgc_pkg::DIV_LAT; i++) begin
                r_dly[i] <= r_dly[i-1];
            end
        end
    end

    // ---------------- stage 6: branch capacitances ---------------------------
    mgc_pkg::t_side w_side6;
    logic [mgc_pkg::CAP_W-1:0] r_s6_cgb;
    logic [mgc_pkg::CAP_W-1:0] r_s6_cgd;
    logic [mgc_pkg::CAP_W-1:0] r_s6_cgs;
    logic [mgc_pkg::VOLT_W-1:0] r_s6_vgb;
    logic [mgc_pkg::VOLT_W-1:0] r_s6_vgd;
    logic [mgc_pkg::VOLT_W-1:0] r_s6_vgs;
    logic                       r_s6_fault;

    assign w_side6 = r_dly[mgc_pkg::DIV_LAT-1];

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s6_cgb   <= w_side6.x_gd ? w_side6.ov_gb
                                       : cap_sum(w_side6.ov_gb, w_qx, w_ovfx, 1'b0);
            r_s6_cgd   <= w_side6.x_gd ? cap_sum(w_side6.ov_gd, w_qx, w_ovfx, w_side6.neg_gd)
                                       : w_side6.ov_gd;
            r_s6_cgs   <= cap_sum(w_side6.ov_gs, w_qy, w_ovfy, w_side6.neg_gs);
            r_s6_vgb   <= w_side6.volt_gb;
            r_s6_vgd   <= w_side6.volt_gd;
            r_s6_vgs   <= w_side6.volt_gs;
            r_s6_fault <= w_side6.fault;
        end
    end

    // ---------------- stage 7: volt times cap --------------------------------
    localparam int PROD_W = mgc_pkg::VOLT_W + mgc_pkg::CAP_W + 1;

    logic [PROD_W-1:0]         r_s7_pgb;
    logic [PROD_W-1:0]         r_s7_pgd;
    logic [PROD_W-1:0]         r_s7_pgs;
    logic [mgc_pkg::CAP_W-1:0] r_s7_cgb;
    logic [mgc_pkg::CAP_W-1:0] r_s7_cgd;
    logic [mgc_pkg::CAP_W-1:0] r_s7_cgs;
    logic                      r_s7_fault;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s7_pgb   <= PROD_W'($signed(r_s6_vgb) * $signed({1'b0, r_s6_cgb}));
            r_s7_pgd   <= PROD_W'($signed(r_s6_vgd) * $signed({1'b0, r_s6_cgd}));
            r_s7_pgs   <= PROD_W'($signed(r_s6_vgs) * $signed({1'b0, r_s6_cgs}));
            r_s7_cgb   <= r_s6_cgb;
            r_s7_cgd   <= r_s6_cgd;
            r_s7_cgs   <= r_s6_cgs;
            r_s7_fault <= r_s6_fault;
        end
    end

    // ---------------- output register ----------------------------------------
    // arithmetic shift floors the charge; the result never reaches the 48-bit limits
    logic [mgc_pkg::CAP_W-1:0] r_out_cgb;
    logic [mgc_pkg::CAP_W-1:0] r_out_cgd;
    logic [mgc_pkg::CAP_W-1:0] r_out_cgs;
    logic [mgc_pkg::CHG_W-1:0] r_out_qgb;
    logic [mgc_pkg::CHG_W-1:0] r_out_qgd;
    logic [mgc_pkg::CHG_W-1:0] r_out_qgs;
    logic                      r_out_fault;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_cgb   <= r_s7_cgb;
            r_out_cgd   <= r_s7_cgd;
            r_out_cgs   <= r_s7_cgs;
            r_out_qgb   <= mgc_pkg::CHG_W'($signed(r_s7_pgb[PROD_W-1:mgc_pkg::VOLT_FRAC_BITS]));
            r_out_qgd   <= mgc_pkg::CHG_W'($signed(r_s7_pgd[PROD_W-1:mgc_pkg::VOLT_FRAC_BITS]));
            r_out_qgs   <= mgc_pkg::CHG_W'($signed(r_s7_pgs[PROD_W-1:mgc_pkg::VOLT_FRAC_BITS]));
            r_out_fault <= r_s7_fault;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.cap_gb       = r_out_cgb;
    assign o_out.cap_gd       = r_out_cgd;
    assign o_out.cap_gs       = r_out_cgs;
    assign o_out.charge_gb    = r_out_qgb;
    assign o_out.charge_gd    = r_out_qgd;
    assign o_out.charge_gs    = r_out_qgs;
    assign o_out.divide_fault = r_out_fault;

endmodule
